/* sv/rational_arithmetic_unit_macros.svh */
// assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`define RAU_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
`else
`define RAU_ASSERT(lbl, prop, msg)
`define RAU_ASSERT_IMP(lbl, pre, post, msg)
`endif

`endif

/* sv/rau_pkg.sv */
`default_nettype none

package rau_pkg;

  localparam int unsigned CMD_W = 2;

  typedef enum logic [CMD_W-1:0] {
    OP_MUL    = 2'd0,
    OP_ADD    = 2'd1,
    OP_REDUCE = 2'd2,
    OP_QUOT   = 2'd3
  } op_e;

  // classification made at the front, carried with each queued word
  typedef struct packed {
    op_e  op;
    logic den_zero;
    logic neg_num;
    logic neg_den;
  } rau_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rau_back_stat_t;

endpackage

`default_nettype wire

/* sv/rau_if.sv */
`default_nettype none

interface rau_in_if #(
  parameter int unsigned W = 16
);
  logic                        valid;
  logic                        ready;
  logic [rau_pkg::CMD_W-1:0]   cmd;
  logic signed [W-1:0]         num_a;
  logic signed [W-1:0]         den_a;
  logic signed [W-1:0]         num_b;
  logic signed [W-1:0]         den_b;

  modport source (output valid, cmd, num_a, den_a, num_b, den_b, input ready);
  modport sink   (input valid, cmd, num_a, den_a, num_b, den_b, output ready);
endinterface

interface rau_out_if #(
  parameter int unsigned W = 16
);
  logic                valid;
  logic                ready;
  logic signed [2*W:0] num_out;
  logic signed [2*W-1:0] den_out;
  logic                status;

  modport source (output valid, num_out, den_out, status, input ready);
  modport sink   (input valid, num_out, den_out, status, output ready);
endinterface

`default_nettype wire

/* sv/rau_front.sv */
`default_nettype none

module rau_front #(
  parameter int unsigned W = 16
) (
  rau_in_if.sink               in_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output rau_pkg::rau_ctrl_t   ctrl_o,
  output logic [6*W-1:0]       data_o
);

  rau_pkg::op_e   op;
  logic [W-1:0]   mag_num;
  logic [W-1:0]   mag_den;

  assign in_i.ready = !q_full_i;
  assign push_o     = in_i.valid && !q_full_i;

  assign op      = rau_pkg::op_e'(in_i.cmd);
  assign mag_num = in_i.num_a[W-1] ? W'(-in_i.num_a) : W'(in_i.num_a);
  assign mag_den = in_i.den_a[W-1] ? W'(-in_i.den_a) : W'(in_i.den_a);

  always_comb begin
    ctrl_o.op       = op;
    ctrl_o.neg_num  = in_i.num_a[W-1];
    ctrl_o.neg_den  = in_i.den_a[W-1];
    // only reduce and quotient care about a zero denominator
    ctrl_o.den_zero = (in_i.den_a == '0) &&
                      ((op == rau_pkg::OP_REDUCE) || (op == rau_pkg::OP_QUOT));
  end

  assign data_o = {mag_num, mag_den, in_i.num_a, in_i.den_a, in_i.num_b, in_i.den_b};

endmodule

`default_nettype wire

/* sv/rau_fifo.sv */
`default_nettype none

module rau_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

/* sv/rau_back.sv */
`default_nettype none

module rau_back #(
  parameter int unsigned W = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  rau_pkg::rau_ctrl_t        ctrl_i,
  input  logic [6*W-1:0]            data_i,
  output logic                      pop_o,
  output rau_pkg::rau_back_stat_t   stat_o,
  rau_out_if.source                 out_o
);

  localparam int unsigned NW = 2 * W + 1;
  localparam int unsigned DW = 2 * W;
  localparam int unsigned CW = $clog2(W);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_ACC  = 6'b000100,
    S_GCD  = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // incoming word
  logic [W-1:0]        in_mag_num, in_mag_den;
  logic signed [W-1:0] in_na, in_da, in_nb, in_db;

  // operand and work registers
  rau_pkg::op_e        op_q, op_d;
  logic                neg_n_q, neg_n_d, neg_d_q, neg_d_d;
  logic signed [W-1:0] na_q, na_d, da_q, da_d, nb_q, nb_d, db_q, db_d;
  logic [W-1:0]        mn_q, mn_d, md_q, md_d;
  logic [1:0]          step_q, step_d;
  logic signed [DW-1:0] prod_q, prod_d;
  logic signed [NW-1:0] rn_q, rn_d;
  logic signed [DW-1:0] rd_q, rd_d;
  logic                st_q, st_d;
  logic [W-1:0]        ga_q, ga_d, gb_q, gb_d;
  logic [CW-1:0]       gk_q, gk_d;
  logic [W-1:0]        dvs_q, dvs_d, dd1_q, dd1_d, dd2_q, dd2_d, r1_q, r1_d, r2_q, r2_d;
  logic [CW-1:0]       cnt_q, cnt_d;

  // result register
  logic                 ov_q, ov_d;
  logic signed [NW-1:0] onum_q, onum_d;
  logic signed [DW-1:0] oden_q, oden_d;
  logic                 ost_q, ost_d;

  // datapath helpers
  logic signed [W-1:0]  mx, my;
  logic signed [NW-1:0] prod_sx;
  logic [W:0]           t1, t2, t1s, t2s;
  logic                 ge1, ge2;
  logic [W-1:0]         r1n, r2n, dd1n, dd2n;
  logic [NW-1:0]        q1z;
  logic [DW-1:0]        q2z;
  logic [W-1:0]         g_or;
  logic                 is_add;

  assign {in_mag_num, in_mag_den, in_na, in_da, in_nb, in_db} = data_i;

  assign is_add = (op_q == rau_pkg::OP_ADD);

  // shared multiplier operand select
  always_comb begin
    case (step_q)
      2'd0: begin
        mx = na_q;
        my = is_add ? db_q : nb_q;
      end
      2'd1: begin
        mx = is_add ? nb_q : da_q;
        my = is_add ? da_q : db_q;
      end
      default: begin
        mx = da_q;
        my = db_q;
      end
    endcase
  end

  assign prod_sx = {prod_q[DW-1], prod_q};

  // restoring divider step, two dividends over one divisor
  assign t1   = {r1_q, dd1_q[W-1]};
  assign t2   = {r2_q, dd2_q[W-1]};
  assign t1s  = t1 - {1'b0, dvs_q};
  assign t2s  = t2 - {1'b0, dvs_q};
  assign ge1  = (t1 >= {1'b0, dvs_q});
  assign ge2  = (t2 >= {1'b0, dvs_q});
  assign r1n  = ge1 ? t1s[W-1:0] : t1[W-1:0];
  assign r2n  = ge2 ? t2s[W-1:0] : t2[W-1:0];
  assign dd1n = {dd1_q[W-2:0], ge1};
  assign dd2n = {dd2_q[W-2:0], ge2};
  assign q1z  = NW'(dd1n);
  assign q2z  = DW'(dd2n);

  assign g_or = ga_q | gb_q;

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    op_d    = op_q;
    neg_n_d = neg_n_q;
    neg_d_d = neg_d_q;
    na_d    = na_q;
    da_d    = da_q;
    nb_d    = nb_q;
    db_d    = db_q;
    mn_d    = mn_q;
    md_d    = md_q;
    step_d  = step_q;
    prod_d  = prod_q;
    rn_d    = rn_q;
    rd_d    = rd_q;
    st_d    = st_q;
    ga_d    = ga_q;
    gb_d    = gb_q;
    gk_d    = gk_q;
    dvs_d   = dvs_q;
    dd1_d   = dd1_q;
    dd2_d   = dd2_q;
    r1_d    = r1_q;
    r2_d    = r2_q;
    cnt_d   = cnt_q;
    ov_d    = ov_q;
    onum_d  = onum_q;
    oden_d  = oden_q;
    ost_d   = ost_q;

    if (ov_q && out_o.ready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          op_d    = ctrl_i.op;
          neg_n_d = ctrl_i.neg_num;
          neg_d_d = ctrl_i.neg_den;
          na_d    = in_na;
          da_d    = in_da;
          nb_d    = in_nb;
          db_d    = in_db;
          mn_d    = in_mag_num;
          md_d    = in_mag_den;
          st_d    = 1'b0;
          step_d  = '0;
          rn_d    = '0;
          rd_d    = '0;
          if (ctrl_i.den_zero) begin
            st_d    = 1'b1;
            state_d = S_DONE;
          end else begin
            unique case (ctrl_i.op)
              rau_pkg::OP_MUL, rau_pkg::OP_ADD: begin
                state_d = S_MUL;
              end
              rau_pkg::OP_REDUCE: begin
                ga_d    = in_mag_num;
                gb_d    = in_mag_den;
                gk_d    = '0;
                state_d = S_GCD;
              end
              default: begin
                dvs_d   = in_mag_den;
                dd1_d   = in_mag_num;
                dd2_d   = in_mag_num;
                r1_d    = '0;
                r2_d    = '0;
                cnt_d   = '0;
                state_d = S_DIV;
              end
            endcase
          end
        end
      end

      S_MUL: begin
        prod_d  = mx * my;
        state_d = S_ACC;
      end

      S_ACC: begin
        case (step_q)
          2'd0: begin
            rn_d    = prod_sx;
            step_d  = 2'd1;
            state_d = S_MUL;
          end
          2'd1: begin
            if (is_add) begin
              rn_d    = rn_q + prod_sx;
              step_d  = 2'd2;
              state_d = S_MUL;
            end else begin
              rd_d    = prod_q;
              state_d = S_DONE;
            end
          end
          default: begin
            rd_d    = prod_q;
            state_d = S_DONE;
          end
        endcase
      end

      // binary gcd, one step a cycle
      S_GCD: begin
        if ((ga_q == '0) || (gb_q == '0)) begin
          dvs_d   = g_or << gk_q;
          dd1_d   = mn_q;
          dd2_d   = md_q;
          r1_d    = '0;
          r2_d    = '0;
          cnt_d   = '0;
          state_d = S_DIV;
        end else if (!ga_q[0] && !gb_q[0]) begin
          ga_d = ga_q >> 1;
          gb_d = gb_q >> 1;
          gk_d = gk_q + 1'b1;
        end else if (!ga_q[0]) begin
          ga_d = ga_q >> 1;
        end else if (!gb_q[0]) begin
          gb_d = gb_q >> 1;
        end else if (ga_q >= gb_q) begin
          ga_d = (ga_q - gb_q) >> 1;
        end else begin
          gb_d = (gb_q - ga_q) >> 1;
        end
      end

      S_DIV: begin
        r1_d  = r1n;
        r2_d  = r2n;
        dd1_d = dd1n;
        dd2_d = dd2n;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(W - 1)) begin
          if (op_q == rau_pkg::OP_QUOT) begin
            rn_d = (neg_n_q ^ neg_d_q) ? NW'(0) - q1z : q1z;
            rd_d = DW'(1);
          end else begin
            rn_d = neg_n_q ? NW'(0) - q1z : q1z;
            rd_d = neg_d_q ? DW'(0) - q2z : q2z;
          end
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!ov_q || out_o.ready) begin
          ov_d    = 1'b1;
          onum_d  = rn_q;
          oden_d  = rd_q;
          ost_d   = st_q;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    neg_n_q <= neg_n_d;
    neg_d_q <= neg_d_d;
    na_q    <= na_d;
    da_q    <= da_d;
    nb_q    <= nb_d;
    db_q    <= db_d;
    mn_q    <= mn_d;
    md_q    <= md_d;
    step_q  <= step_d;
    prod_q  <= prod_d;
    rn_q    <= rn_d;
    rd_q    <= rd_d;
    st_q    <= st_d;
    ga_q    <= ga_d;
    gb_q    <= gb_d;
    gk_q    <= gk_d;
    dvs_q   <= dvs_d;
    dd1_q   <= dd1_d;
    dd2_q   <= dd2_d;
    r1_q    <= r1_d;
    r2_q    <= r2_d;
    cnt_q   <= cnt_d;
    onum_q  <= onum_d;
    oden_q  <= oden_d;
    ost_q   <= ost_d;
  end

  assign out_o.valid   = ov_q;
  assign out_o.num_out = onum_q;
  assign out_o.den_out = oden_q;
  assign out_o.status  = ost_q;

  assign stat_o.busy = (state_q != S_IDLE);
  assign stat_o.done = (state_q == S_DONE);

endmodule

`default_nettype wire

/* sv/rational_arithmetic_unit.sv */
// channel  dir  handshake      word
// in_i     in   valid/ready    cmd, num_a, den_a, num_b, den_b
// out_o    out  valid/ready    num_out, den_out, status
//
// steps from accept to result: multiply and add use the shared multiplier, quotient
// runs the shared restoring divider, and reduce runs a binary gcd of under 2W steps,
// hands over, then runs W steps of the shared restoring divider; W is OPERAND_WIDTH
// a 2-word queue sits between the classifying front and the executing back,
// so input is taken while the back works; the back runs one word at a time
// the result register holds until taken, and the back waits in its done state
// reset empties the queue and drops any pending result; no clearing pass
`default_nettype none

`include "rational_arithmetic_unit_macros.svh"

module rational_arithmetic_unit #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rau_in_if.sink     in_i,
  rau_out_if.source  out_o
);

  localparam int unsigned W           = OPERAND_WIDTH;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned DATA_W      = 6 * W;
  localparam int unsigned CTRL_W      = $bits(rau_pkg::rau_ctrl_t);
  localparam int unsigned ENTRY_W     = CTRL_W + DATA_W;

  logic                    push, q_full, pop, q_valid;
  rau_pkg::rau_ctrl_t      ctrl_f, ctrl_b;
  logic [DATA_W-1:0]       data_f, data_b;
  logic [ENTRY_W-1:0]      q_rdata;
  rau_pkg::rau_back_stat_t back_st;

  rau_front #(.W(W)) u_front (
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .ctrl_o   (ctrl_f),
    .data_o   (data_f)
  );

  rau_fifo #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({ctrl_f, data_f}),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  assign ctrl_b = rau_pkg::rau_ctrl_t'(q_rdata[ENTRY_W-1 -: CTRL_W]);
  assign data_b = q_rdata[DATA_W-1:0];

  rau_back #(.W(W)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .ctrl_i    (ctrl_b),
    .data_i    (data_b),
    .pop_o     (pop),
    .stat_o    (back_st),
    .out_o     (out_o)
  );

  // error word carries a zero fraction
  `RAU_ASSERT_IMP(a_err_zero, out_o.valid && out_o.status, (out_o.num_out == '0) && (out_o.den_out == '0), "error result not zero")
  // back starts only on a queued word
  `RAU_ASSERT_IMP(a_start_queued, $rose(back_st.busy), $past(q_valid), "back started without a queued word")
  // a fresh result comes only out of the done state
  `RAU_ASSERT(a_result_src, $rose(out_o.valid) |-> $past(back_st.done), "result valid without finish")

endmodule

`default_nettype wire
